// File: src/vnu_pkg.sv
`default_nettype none
package vnu_pkg;

   localparam int ELEMENT_WIDTH  = 32;
   localparam int ACC_WIDTH      = 64;
   localparam int NORM_WIDTH     = 48;
   localparam int MODE_WIDTH     = 2;
   localparam int RSP_DATA_WIDTH = 48;
   localparam int RSP_USER_WIDTH = 2;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam int QDEPTH       = 4;
   localparam int QPTR_WIDTH   = 2;
   localparam int QCOUNT_WIDTH = 3;

   localparam logic [MODE_WIDTH-1:0] MODE_INF   = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_ONE   = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_TWO   = 2'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_BAD   = 2'd3;
   localparam logic [MODE_WIDTH-1:0] MODE_RESET = MODE_TWO;

   localparam logic [0:0] REG_NORM_MODE = 1'b0;

   localparam logic [ACC_WIDTH-1:0] ROOT_BIT_INIT = ACC_WIDTH'(1) << (ACC_WIDTH - 2);

   typedef struct packed {
      logic [ACC_WIDTH-1:0]  acc;
      logic                  ovf;
      logic [MODE_WIDTH-1:0] mode;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

endpackage
`default_nettype wire

// File: src/vnu_front.sv
`default_nettype none
module vnu_front (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire  [vnu_pkg::ELEMENT_WIDTH-1:0]     req_tdata,   // element
   input  wire                                   req_tlast,
   input  wire  [vnu_pkg::MODE_WIDTH-1:0]        mode,
   input  wire  [vnu_pkg::QCOUNT_WIDTH-1:0]      q_count,
   output vnu_pkg::push_type                     push
);

   localparam int EW = vnu_pkg::ELEMENT_WIDTH;
   localparam int AW = vnu_pkg::ACC_WIDTH;
   localparam int MW = vnu_pkg::MODE_WIDTH;
   localparam int CW = vnu_pkg::QCOUNT_WIDTH;

   logic          s1_valid_ff, s1_valid_in;
   logic          s1_last_ff;
   logic [MW-1:0] s1_mode_ff;
   logic [EW-1:0] s1_mag_ff, s1_mag_in;

   logic          s2_valid_ff;
   logic          s2_last_ff;
   logic [MW-1:0] s2_mode_ff;
   logic [EW-1:0] s2_mag_ff;
   logic [AW-1:0] s2_prod_ff, s2_prod_in;

   logic [AW-1:0] acc_ff, acc_in, acc_next, addend, mag_ext;
   logic          ovf_ff, ovf_in, ovf_next;
   logic [AW:0]   sum;
   logic [CW-1:0] pending;
   logic          accept;

   always_comb begin
      pending    = q_count + CW'(s1_valid_ff & s1_last_ff) + CW'(s2_valid_ff & s2_last_ff);
      req_tready = pending < CW'(vnu_pkg::QDEPTH);
      accept     = req_tvalid & req_tready;
      s1_valid_in = accept;
      s1_mag_in  = req_tdata[EW-1] ? (~req_tdata + EW'(1)) : req_tdata;
      s2_prod_in = AW'(s1_mag_ff) * AW'(s1_mag_ff);
   end

   always_comb begin
      mag_ext  = AW'(s2_mag_ff);
      addend   = (s2_mode_ff == vnu_pkg::MODE_TWO) ? s2_prod_ff : mag_ext;
      sum      = {1'b0, acc_ff} + {1'b0, addend};
      acc_next = acc_ff;
      ovf_next = ovf_ff;
      unique case (s2_mode_ff)
         vnu_pkg::MODE_INF: begin
            if (mag_ext > acc_ff) begin
               acc_next = mag_ext;
            end
         end
         vnu_pkg::MODE_ONE, vnu_pkg::MODE_TWO: begin
            if (sum[AW]) begin
               acc_next = '1;
               ovf_next = 1'b1;
            end else begin
               acc_next = sum[AW-1:0];
            end
         end
         default: begin
            acc_next = acc_ff;
         end
      endcase
      acc_in = acc_ff;
      ovf_in = ovf_ff;
      if (s2_valid_ff) begin
         acc_in = s2_last_ff ? '0 : acc_next;
         ovf_in = s2_last_ff ? 1'b0 : ovf_next;
      end
      push.valid    = s2_valid_ff & s2_last_ff;
      push.job.acc  = acc_next;
      push.job.ovf  = ovf_next;
      push.job.mode = s2_mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         acc_ff      <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         acc_ff      <= acc_in;
         ovf_ff      <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mag_ff  <= s1_mag_in;
         s1_last_ff <= req_tlast;
         s1_mode_ff <= mode;
      end
      s2_mag_ff  <= s1_mag_ff;
      s2_prod_ff <= s2_prod_in;
      s2_last_ff <= s1_last_ff;
      s2_mode_ff <= s1_mode_ff;
   end

endmodule
`default_nettype wire

// File: src/vnu_queue.sv
`default_nettype none
module vnu_queue (
   input  wire                                clock,
   input  wire                                reset,
   input  wire vnu_pkg::push_type             push,
   input  wire                                pop,
   output logic                               q_valid,
   output vnu_pkg::job_type                   q_job,
   output logic [vnu_pkg::QCOUNT_WIDTH-1:0]   q_count
);

   localparam int PW = vnu_pkg::QPTR_WIDTH;
   localparam int CW = vnu_pkg::QCOUNT_WIDTH;

   vnu_pkg::job_type mem_ff [vnu_pkg::QDEPTH];
   logic [PW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_pop;

   always_comb begin
      q_valid  = count_ff != '0;
      q_job    = mem_ff[head_ff];
      q_count  = count_ff;
      do_pop   = pop & q_valid;
      head_in  = do_pop ? head_ff + PW'(1) : head_ff;
      tail_in  = push.valid ? tail_ff + PW'(1) : tail_ff;
      count_in = count_ff + CW'(push.valid) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[tail_ff] <= push.job;
      end
   end

endmodule
`default_nettype wire

// File: src/vnu_back.sv
`default_nettype none
module vnu_back (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    q_valid,
   input  wire vnu_pkg::job_type                  q_job,
   output logic                                   pop,
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   output logic [vnu_pkg::RSP_DATA_WIDTH-1:0]     rsp_tdata,  // norm_value
   output logic [vnu_pkg::RSP_USER_WIDTH-1:0]     rsp_tuser   // saturated, mode_error
);

   localparam int AW = vnu_pkg::ACC_WIDTH;
   localparam int NW = vnu_pkg::NORM_WIDTH;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ROOT = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] n_ff, n_in, root_ff, root_in, bit_ff, bit_in, trial;
   logic          sat_ff, sat_in;

   logic          out_valid_ff, out_valid_in;
   logic [NW-1:0] out_value_ff, out_value_in;
   logic          out_sat_ff, out_sat_in, out_err_ff, out_err_in;

   logic          out_free, load;
   logic [NW-1:0] load_value;
   logic          load_sat, load_err;

   always_comb begin
      out_free   = !out_valid_ff || rsp_tready;
      trial      = root_ff + bit_ff;
      state_in   = state_ff;
      n_in       = n_ff;
      root_in    = root_ff;
      bit_in     = bit_ff;
      sat_in     = sat_ff;
      pop        = 1'b0;
      load       = 1'b0;
      load_value = '0;
      load_sat   = q_job.ovf;
      load_err   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               unique case (q_job.mode)
                  vnu_pkg::MODE_TWO: begin
                     pop      = 1'b1;
                     n_in     = q_job.acc;
                     root_in  = '0;
                     bit_in   = vnu_pkg::ROOT_BIT_INIT;
                     sat_in   = q_job.ovf;
                     state_in = ST_ROOT;
                  end
                  vnu_pkg::MODE_INF, vnu_pkg::MODE_ONE: begin
                     pop  = out_free;
                     load = out_free;
                     if (|q_job.acc[AW-1:NW]) begin
                        load_value = '1;
                        load_sat   = 1'b1;
                     end else begin
                        load_value = q_job.acc[NW-1:0];
                     end
                  end
                  default: begin
                     pop      = out_free;
                     load     = out_free;
                     load_err = 1'b1;
                  end
               endcase
            end
         end
         ST_ROOT: begin
            if (n_ff >= trial) begin
               n_in    = n_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            load       = out_free;
            load_value = root_ff[NW-1:0];
            load_sat   = sat_ff;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      out_valid_in = load | (out_valid_ff & !rsp_tready);
      out_value_in = load ? load_value : out_value_ff;
      out_sat_in   = load ? load_sat : out_sat_ff;
      out_err_in   = load ? load_err : out_err_ff;
      rsp_tvalid   = out_valid_ff;
      rsp_tdata    = out_value_ff;
      rsp_tuser    = {out_err_ff, out_sat_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      root_ff      <= root_in;
      bit_ff       <= bit_in;
      sat_ff       <= sat_in;
      out_value_ff <= out_value_in;
      out_sat_ff   <= out_sat_in;
      out_err_ff   <= out_err_in;
   end

endmodule
`default_nettype wire

// File: src/vector_norm_unit.sv
// Elements: one item per cycle unless stalled; each passes stage 1 and stage 2 registers
// before the accumulator. All results pass the queue and output register; the two-norm also
// waits for the 32-step bit-pair square root in the back end, one vector at a time.
// A 4-entry queue of finished sums lets accumulation of later vectors overlap the square root;
// input stalls while four finished vectors are queued or in flight.
// Synchronous reset clears the accumulator, the queue and the output; norm_mode returns to 2.
`default_nettype none
module vector_norm_unit (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_tvalid,
   output logic                                   req_tready,
   input  wire  [vnu_pkg::ELEMENT_WIDTH-1:0]      req_tdata,   // element
   input  wire                                    req_tlast,
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   output logic [vnu_pkg::RSP_DATA_WIDTH-1:0]     rsp_tdata,   // norm_value
   output logic [vnu_pkg::RSP_USER_WIDTH-1:0]     rsp_tuser,   // saturated, mode_error
   input  wire                                    csr_psel,
   input  wire                                    csr_penable,
   input  wire                                    csr_pwrite,
   input  wire  [vnu_pkg::CSR_ADDR_WIDTH-1:0]     csr_paddr,
   input  wire  [vnu_pkg::CSR_DATA_WIDTH-1:0]     csr_pwdata,
   output logic [vnu_pkg::CSR_DATA_WIDTH-1:0]     csr_prdata,
   output logic                                   csr_pready
);

   logic [vnu_pkg::MODE_WIDTH-1:0]   mode_ff, mode_in;
   logic                             csr_hit;
   logic [vnu_pkg::QCOUNT_WIDTH-1:0] q_count;
   logic                             q_valid, pop;
   vnu_pkg::job_type                 q_job;
   vnu_pkg::push_type                push;

   always_comb begin
      csr_pready = 1'b1;
      csr_hit    = csr_paddr[vnu_pkg::CSR_ADDR_WIDTH-1] == vnu_pkg::REG_NORM_MODE;
      mode_in    = (csr_psel & csr_penable & csr_pwrite & csr_pready & csr_hit)
                   ? csr_pwdata[vnu_pkg::MODE_WIDTH-1:0] : mode_ff;
      csr_prdata = csr_hit ? vnu_pkg::CSR_DATA_WIDTH'(mode_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= vnu_pkg::MODE_RESET;
      end else begin
         mode_ff <= mode_in;
      end
   end

   vnu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .mode       (mode_ff),
      .q_count    (q_count),
      .push       (push)
   );

   vnu_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .pop     (pop),
      .q_valid (q_valid),
      .q_job   (q_job),
      .q_count (q_count)
   );

   vnu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_job      (q_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire
